// File: hw/rtl/aabb_dcr_pkg.sv
// shared types and constants for the aabb directional clip resolver
// beat structs, gap record, state encoding and operation codes; no dependencies
`default_nettype none

package aabb_dcr_pkg;

    localparam int COORD_W = 32;
    localparam int SIZE_W  = COORD_W - 1;
    localparam int GAP_W   = COORD_W - 1;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int DIST_W  = COORD_W + 2;
    localparam int INDEX_W = 8;

    localparam logic OP_DETECT  = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    localparam logic [GAP_W-1:0] GAP_MAX = '1;

    typedef struct packed {
        logic                       operation;
        logic [INDEX_W-1:0]         target_index;
        logic signed [COORD_W-1:0]  self_x;
        logic signed [COORD_W-1:0]  self_y;
        logic [SIZE_W-1:0]          self_width;
        logic [SIZE_W-1:0]          self_height;
        logic signed [COORD_W-1:0]  other_x;
        logic signed [COORD_W-1:0]  other_y;
        logic [SIZE_W-1:0]          other_width;
        logic [SIZE_W-1:0]          other_height;
        logic                       self_solid;
        logic                       other_solid;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] new_x;
        logic signed [COORD_W-1:0] new_y;
    } result_t;

    typedef struct packed {
        logic [GAP_W-1:0] north;
        logic [GAP_W-1:0] east;
        logic [GAP_W-1:0] south;
        logic [GAP_W-1:0] west;
    } gaps_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDGE,
        ST_TEST,
        ST_UPDATE
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/aabb_dcr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module aabb_dcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/aabb_directional_clip_resolver.sv
// aabb directional clip resolver: per-object blocker distances on four sides
// depends on aabb_dcr_pkg and aabb_dcr_ram
//
// usage
//   item channel (item_valid/item_ready/item): detect beats lower one side's
//   stored gap for target_index when both boxes are solid and the first box
//   lies wholly north, east, south or west of the target with overlap on the
//   other axis; resolve beats clamp the motion from the last to the current
//   position by the stored gaps and return the corrected position
//   result channel (result_valid/result_ready/result): one beat per resolve,
//   none per detect
//   each item is one read-modify-write of the gap ram: accept and read, edge
//   sums, side tests, update; the next item is accepted only after the update
//   step, and a resolve registers its result in that update step
//   the result sits in an output register, so a stalled receiver does not
//   block the next item; only a resolve that finds the output register still
//   full waits in its update step
//   reset clears the per-entry valid flags, so every gap reads as the maximum
//   at once; no clearing pass is needed
`default_nettype none

module aabb_directional_clip_resolver #(
    parameter int OBJECT_COUNT = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire aabb_dcr_pkg::item_t   item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output aabb_dcr_pkg::result_t      result
);

    localparam int COORD_W   = aabb_dcr_pkg::COORD_W;
    localparam int GAP_W     = aabb_dcr_pkg::GAP_W;
    localparam int EDGE_W    = aabb_dcr_pkg::EDGE_W;
    localparam int DIST_W    = aabb_dcr_pkg::DIST_W;
    localparam int INDEX_SPAN = 2 ** aabb_dcr_pkg::INDEX_W;
    localparam int MEM_DEPTH = (OBJECT_COUNT < INDEX_SPAN) ? OBJECT_COUNT : INDEX_SPAN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int GAPS_W    = $bits(aabb_dcr_pkg::gaps_t);

    aabb_dcr_pkg::state_t  state_reg, state_next;
    aabb_dcr_pkg::item_t   item_reg;
    aabb_dcr_pkg::result_t result_reg, result_next;
    logic                  result_valid_reg, result_valid_next;
    logic [MEM_DEPTH-1:0]  valid_reg, valid_next;

    logic signed [EDGE_W-1:0] r1_reg, b1_reg, r2_reg, b2_reg;
    logic signed [EDGE_W-1:0] dx_reg, dy_reg, ndx_reg, ndy_reg;
    logic signed [DIST_W-1:0] dist_n_reg, dist_e_reg, dist_s_reg, dist_w_reg;
    logic                     hit_n_reg, hit_e_reg, hit_s_reg, hit_w_reg;

    logic              accept;
    logic              load_edge, load_test, load_result;
    logic              ram_wr_en, set_valid, clear_valid;
    logic [ADDR_W-1:0] addr;
    logic              in_range, entry_live, solid;
    logic [GAPS_W-1:0] ram_rd_data;
    aabb_dcr_pkg::gaps_t gaps_cur, gaps_new;

    logic align_x, align_y;
    logic out_free;
    logic clip_s, clip_n, clip_e, clip_w;
    logic signed [COORD_W-1:0] nx, ny;

    function automatic logic [GAP_W-1:0] lower_gap(
        input logic [GAP_W-1:0]        stored,
        input logic                    hit,
        input logic signed [DIST_W-1:0] span
    );
        logic [GAP_W-1:0] cand;
        cand = (|span[DIST_W-2:GAP_W]) ? aabb_dcr_pkg::GAP_MAX : span[GAP_W-1:0];
        return (hit && (cand < stored)) ? cand : stored;
    endfunction

    assign accept   = item_valid && item_ready;
    assign addr     = item_reg.target_index[ADDR_W-1:0];
    assign in_range = 32'(item_reg.target_index) < OBJECT_COUNT;
    assign entry_live = in_range && valid_reg[addr];
    assign solid    = item_reg.self_solid && item_reg.other_solid;
    assign gaps_cur = entry_live ? aabb_dcr_pkg::gaps_t'(ram_rd_data) : '1;
    assign out_free = !result_valid_reg || result_ready;

    aabb_dcr_ram #(
        .WIDTH (GAPS_W),
        .DEPTH (MEM_DEPTH)
    ) u_gap_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr),
        .wr_data (GAPS_W'(gaps_new)),
        .rd_en   (accept),
        .rd_addr (item.target_index[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        item_ready  = 1'b0;
        load_edge   = 1'b0;
        load_test   = 1'b0;
        load_result = 1'b0;
        ram_wr_en   = 1'b0;
        set_valid   = 1'b0;
        clear_valid = 1'b0;
        unique case (state_reg)
            aabb_dcr_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    state_next = aabb_dcr_pkg::ST_EDGE;
                end
            end
            aabb_dcr_pkg::ST_EDGE:
            begin
                load_edge  = 1'b1;
                state_next = aabb_dcr_pkg::ST_TEST;
            end
            aabb_dcr_pkg::ST_TEST:
            begin
                load_test  = 1'b1;
                state_next = aabb_dcr_pkg::ST_UPDATE;
            end
            aabb_dcr_pkg::ST_UPDATE:
            begin
                if (item_reg.operation == aabb_dcr_pkg::OP_DETECT)
                begin
                    ram_wr_en  = in_range && solid;
                    set_valid  = in_range && solid;
                    state_next = aabb_dcr_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    load_result = 1'b1;
                    clear_valid = in_range;
                    state_next  = aabb_dcr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aabb_dcr_pkg::ST_IDLE;
            end
        endcase
    end

    // side tests
    always_comb
    begin
        align_x = (item_reg.self_width != '0) && (item_reg.other_width != '0)
               && (EDGE_W'(item_reg.self_x) < r2_reg)
               && (EDGE_W'(item_reg.other_x) < r1_reg);
        align_y = (item_reg.self_height != '0) && (item_reg.other_height != '0)
               && (EDGE_W'(item_reg.self_y) < b2_reg)
               && (EDGE_W'(item_reg.other_y) < b1_reg);
    end

    // gap update for detect
    always_comb
    begin
        gaps_new.north = lower_gap(gaps_cur.north, hit_n_reg, dist_n_reg);
        gaps_new.east  = lower_gap(gaps_cur.east,  hit_e_reg, dist_e_reg);
        gaps_new.south = lower_gap(gaps_cur.south, hit_s_reg, dist_s_reg);
        gaps_new.west  = lower_gap(gaps_cur.west,  hit_w_reg, dist_w_reg);
    end

    // motion clamp for resolve
    always_comb
    begin
        clip_s = (gaps_cur.south != aabb_dcr_pkg::GAP_MAX)
              && (dy_reg > $signed(EDGE_W'(gaps_cur.south)));
        clip_n = (gaps_cur.north != aabb_dcr_pkg::GAP_MAX)
              && (ndy_reg > $signed(EDGE_W'(gaps_cur.north)));
        clip_e = (gaps_cur.east != aabb_dcr_pkg::GAP_MAX)
              && (dx_reg > $signed(EDGE_W'(gaps_cur.east)));
        clip_w = (gaps_cur.west != aabb_dcr_pkg::GAP_MAX)
              && (ndx_reg > $signed(EDGE_W'(gaps_cur.west)));
        priority if (clip_s)
            ny = item_reg.other_y + $signed({1'b0, gaps_cur.south});
        else if (clip_n)
            ny = item_reg.other_y - $signed({1'b0, gaps_cur.north});
        else
            ny = item_reg.self_y;
        priority if (clip_e)
            nx = item_reg.other_x + $signed({1'b0, gaps_cur.east});
        else if (clip_w)
            nx = item_reg.other_x - $signed({1'b0, gaps_cur.west});
        else
            nx = item_reg.self_x;
    end

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (load_result)
        begin
            result_next.new_x = nx;
            result_next.new_y = ny;
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (set_valid)
        begin
            valid_next[addr] = 1'b1;
        end
        if (clear_valid)
        begin
            valid_next[addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= aabb_dcr_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
            valid_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            valid_reg        <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            item_reg <= item;
        end
        if (load_edge)
        begin
            r1_reg  <= EDGE_W'(item_reg.self_x)  + EDGE_W'(item_reg.self_width);
            b1_reg  <= EDGE_W'(item_reg.self_y)  + EDGE_W'(item_reg.self_height);
            r2_reg  <= EDGE_W'(item_reg.other_x) + EDGE_W'(item_reg.other_width);
            b2_reg  <= EDGE_W'(item_reg.other_y) + EDGE_W'(item_reg.other_height);
            dx_reg  <= EDGE_W'(item_reg.self_x)  - EDGE_W'(item_reg.other_x);
            dy_reg  <= EDGE_W'(item_reg.self_y)  - EDGE_W'(item_reg.other_y);
            ndx_reg <= EDGE_W'(item_reg.other_x) - EDGE_W'(item_reg.self_x);
            ndy_reg <= EDGE_W'(item_reg.other_y) - EDGE_W'(item_reg.self_y);
        end
        if (load_test)
        begin
            hit_n_reg  <= align_x && (b1_reg <= EDGE_W'(item_reg.other_y));
            hit_e_reg  <= align_y && (EDGE_W'(item_reg.self_x) >= r2_reg);
            hit_s_reg  <= align_x && (EDGE_W'(item_reg.self_y) >= b2_reg);
            hit_w_reg  <= align_y && (r1_reg <= EDGE_W'(item_reg.other_x));
            dist_n_reg <= DIST_W'(item_reg.other_y) - DIST_W'(b1_reg);
            dist_e_reg <= DIST_W'(item_reg.self_x)  - DIST_W'(r2_reg);
            dist_s_reg <= DIST_W'(item_reg.self_y)  - DIST_W'(b2_reg);
            dist_w_reg <= DIST_W'(item_reg.other_x) - DIST_W'(r1_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
